// ===== hdl/radix_conversion_top_defines.svh =====
// ----------------------------------------------------------------------------
// Radix conversion assertion macros
// Shared concurrent-check wrappers, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RADIX_CONVERSION_TOP_DEFINES_SVH
`define RADIX_CONVERSION_TOP_DEFINES_SVH

// same-cycle implication
`define RC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rc_pkg.sv =====
// ----------------------------------------------------------------------------
// Radix conversion package
// Payload types, microcode word layout, control store and digit helpers.
// ----------------------------------------------------------------------------
package rc_pkg;

  localparam int CHAR_W    = 8;
  localparam int BASE_W    = 6;
  localparam int DIGIT_W   = 7;
  localparam int STORE_W   = 6;
  localparam int REM_W     = 7;
  localparam int UPC_W     = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO   = 8'd48;
  localparam logic [CHAR_W:0]    LETTER_OFS   = 9'd55;
  localparam logic [DIGIT_W-1:0] DIGIT_ZERO   = 7'd48;
  localparam logic [DIGIT_W-1:0] DIGIT_LETTER = 7'd55;
  localparam logic [STORE_W-1:0] DEC_RADIX    = 6'd10;
  localparam logic [BASE_W-1:0]  BASE_MIN     = 6'd2;
  localparam logic [BASE_W-1:0]  BASE_MAX     = 6'd36;
  localparam logic [BASE_W-1:0]  IN_BASE_RST  = 6'd10;
  localparam logic [BASE_W-1:0]  OUT_BASE_RST = 6'd16;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              is_last;
  } in_item_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit_out;
    logic               last_digit;
  } out_item_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_BASE  = 1'b0,
    REG_OUT_BASE = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    OP_NOP    = 4'd0,
    OP_MUL    = 4'd1,
    OP_ADD    = 4'd2,
    OP_DINIT  = 4'd3,
    OP_DSTART = 4'd4,
    OP_DSTEP  = 4'd5,
    OP_DSTORE = 4'd6,
    OP_READ   = 4'd7,
    OP_PUSH   = 4'd8
  } op_e;

  // branch taken when the condition holds, else fall through
  typedef enum logic [2:0] {
    C_NEVER       = 3'd0,
    C_ALWAYS      = 3'd1,
    C_IN_WAIT     = 3'd2,
    C_NOT_LAST    = 3'd3,
    C_ITER_MORE   = 3'd4,
    C_MORE_DIGITS = 3'd5,
    C_OUT_FULL    = 3'd6,
    C_PTR_MORE    = 3'd7
  } cond_e;

  typedef struct packed {
    logic              in_rdy;
    op_e               op;
    cond_e             cond;
    logic [UPC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic last;
    logic iter_more;
    logic more_digits;
    logic out_full;
    logic ptr_more;
  } status_t;

  localparam logic [UPC_W-1:0] UA_IDLE   = 4'd0;
  localparam logic [UPC_W-1:0] UA_MUL    = 4'd1;
  localparam logic [UPC_W-1:0] UA_ADD    = 4'd2;
  localparam logic [UPC_W-1:0] UA_DINIT  = 4'd3;
  localparam logic [UPC_W-1:0] UA_DSTART = 4'd4;
  localparam logic [UPC_W-1:0] UA_DSTEP  = 4'd5;
  localparam logic [UPC_W-1:0] UA_DSTORE = 4'd6;
  localparam logic [UPC_W-1:0] UA_READ   = 4'd7;
  localparam logic [UPC_W-1:0] UA_WAIT   = 4'd8;
  localparam logic [UPC_W-1:0] UA_PUSH   = 4'd9;
  localparam logic [UPC_W-1:0] UA_DONE   = 4'd10;

  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] addr);
    uword_t w;
    case (addr)
      UA_IDLE:   w = '{1'b1, OP_NOP,    C_IN_WAIT,     UA_IDLE};
      UA_MUL:    w = '{1'b0, OP_MUL,    C_NEVER,       UA_IDLE};
      UA_ADD:    w = '{1'b0, OP_ADD,    C_NOT_LAST,    UA_IDLE};
      UA_DINIT:  w = '{1'b0, OP_DINIT,  C_NEVER,       UA_IDLE};
      UA_DSTART: w = '{1'b0, OP_DSTART, C_NEVER,       UA_IDLE};
      UA_DSTEP:  w = '{1'b0, OP_DSTEP,  C_ITER_MORE,   UA_DSTEP};
      UA_DSTORE: w = '{1'b0, OP_DSTORE, C_MORE_DIGITS, UA_DSTART};
      UA_READ:   w = '{1'b0, OP_READ,   C_NEVER,       UA_IDLE};
      UA_WAIT:   w = '{1'b0, OP_NOP,    C_OUT_FULL,    UA_WAIT};
      UA_PUSH:   w = '{1'b0, OP_PUSH,   C_PTR_MORE,    UA_READ};
      UA_DONE:   w = '{1'b0, OP_NOP,    C_ALWAYS,      UA_IDLE};
      default:   w = '{1'b0, OP_NOP,    C_ALWAYS,      UA_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [DIGIT_W-1:0] digit_char(input logic [STORE_W-1:0] r);
    logic [DIGIT_W-1:0] rx;
    rx = DIGIT_W'(r);
    return (r >= DEC_RADIX) ? rx + DIGIT_LETTER : rx + DIGIT_ZERO;
  endfunction

  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] c;
    if (b < BASE_MIN) begin
      c = BASE_MIN;
    end else if (b > BASE_MAX) begin
      c = BASE_MAX;
    end else begin
      c = b;
    end
    return c;
  endfunction

endpackage

// ===== hdl/rc_seq.sv =====
// ----------------------------------------------------------------------------
// Radix conversion sequencer
// Micro-PC, control store lookup and conditional branch select.
// ----------------------------------------------------------------------------
module rc_seq
  import rc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  status_t status_i,
  output logic    in_ready_o,
  output op_e     op_o
);

  logic [UPC_W-1:0] upc_q, upc_d;
  uword_t           uw;
  logic             take;

  assign uw = ucode_rom(upc_q);

  always_comb begin
    case (uw.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_IN_WAIT:     take = !in_valid_i;
      C_NOT_LAST:    take = !status_i.last;
      C_ITER_MORE:   take = status_i.iter_more;
      C_MORE_DIGITS: take = status_i.more_digits;
      C_OUT_FULL:    take = status_i.out_full;
      C_PTR_MORE:    take = status_i.ptr_more;
      default:       take = 1'b1;
    endcase
    upc_d = take ? uw.target : upc_q + UPC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UA_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign in_ready_o = uw.in_rdy;
  assign op_o       = uw.op;

endmodule

// ===== hdl/rc_dp.sv =====
// ----------------------------------------------------------------------------
// Radix conversion datapath
// Accumulator, bit-serial divider, digit store and output register.
// ----------------------------------------------------------------------------
module rc_dp
  import rc_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BASE_W-1:0]    cfg_data_i,
  input  logic                 in_accept_i,
  input  in_item_t             in_data_i,
  input  op_e                  op_i,
  output status_t              status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o
);

  localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int IW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic [BASE_W-1:0]     in_base_q, out_base_q, base_q;
  logic [CHAR_W-1:0]     char_q;
  logic                  last_q;
  logic [VALUE_BITS-1:0] acc_q, prod_q, quo_q;
  logic [REM_W-1:0]      rem_q;
  logic [IW-1:0]         iter_q;
  logic [CW-1:0]         cnt_q;
  logic [AW-1:0]         ptr_q;
  logic [STORE_W-1:0]    rdata_q;
  logic                  out_valid_q;
  out_item_t             out_q;
  logic [STORE_W-1:0]    mem_q [MAX_DIGITS];

  logic [VALUE_BITS-1:0] char_val;
  logic signed [CHAR_W:0] char_diff;
  logic [REM_W-1:0]      shifted;
  logic                  fits;

  // digits map to 0..9, everything else to code - 55 with wrap
  always_comb begin
    char_diff = $signed({1'b0, char_q}) - $signed(LETTER_OFS);
    if (char_q inside {[8'd48:8'd57]}) begin
      char_val = VALUE_BITS'(char_q - ASCII_ZERO);
    end else begin
      char_val = VALUE_BITS'(char_diff);
    end
  end

  assign shifted = {rem_q[REM_W-2:0], quo_q[VALUE_BITS-1]};
  assign fits    = shifted >= REM_W'(base_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_base_q   <= IN_BASE_RST;
      out_base_q  <= OUT_BASE_RST;
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_IN_BASE:  in_base_q  <= cfg_data_i;
          REG_OUT_BASE: out_base_q <= cfg_data_i;
          default:      ;
        endcase
      end
      // a push loads the slot, so it never clears in the same cycle
      if (out_ready_i && (op_i != OP_PUSH)) begin
        out_valid_q <= 1'b0;
      end
      case (op_i)
        OP_ADD:    acc_q <= prod_q + char_val;
        OP_DINIT: begin
          acc_q <= '0;
          cnt_q <= '0;
        end
        OP_DSTORE: cnt_q <= cnt_q + CW'(1);
        OP_PUSH:   out_valid_q <= 1'b1;
        default:   ;
      endcase
    end
  end

  // payload, product, divider, digit store and output registers
  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      char_q <= in_data_i.char_in;
      last_q <= in_data_i.is_last;
    end
    case (op_i)
      OP_MUL:    prod_q <= VALUE_BITS'(acc_q * in_base_q);
      OP_DINIT: begin
        quo_q  <= acc_q;
        base_q <= clamp_base(out_base_q);
      end
      OP_DSTART: begin
        rem_q  <= '0;
        iter_q <= IW'(VALUE_BITS - 1);
      end
      OP_DSTEP: begin
        rem_q  <= fits ? shifted - REM_W'(base_q) : shifted;
        quo_q  <= {quo_q[VALUE_BITS-2:0], fits};
        iter_q <= iter_q - IW'(1);
      end
      OP_DSTORE: begin
        mem_q[cnt_q[AW-1:0]] <= rem_q[STORE_W-1:0];
        ptr_q                <= cnt_q[AW-1:0];
      end
      OP_READ:   rdata_q <= mem_q[ptr_q];
      OP_PUSH: begin
        out_q.digit_out  <= digit_char(rdata_q);
        out_q.last_digit <= (ptr_q == '0);
        ptr_q            <= ptr_q - AW'(1);
      end
      default:   ;
    endcase
  end

  assign status_o.last        = last_q;
  assign status_o.iter_more   = (iter_q != '0);
  assign status_o.more_digits = (quo_q != '0) && ((cnt_q + CW'(1)) < CW'(MAX_DIGITS));
  assign status_o.out_full    = out_valid_q && !out_ready_i;
  assign status_o.ptr_more    = (ptr_q != '0);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/radix_conversion_top.sv =====
// ----------------------------------------------------------------------------
// Radix conversion top level
// Accumulates digit characters in one radix, emits them in another.
// ----------------------------------------------------------------------------
// Each input transaction carries one ASCII digit ('0'-'9', else code - 55) and
// is folded into a VALUE_BITS accumulator as value * in_base + digit. A
// transaction with is_last set closes the number: the value is converted to
// out_base (clamped to 2..36) and its digits leave most significant first,
// one output transaction per digit, last_digit set on the final one; a zero
// value gives "0". At most MAX_DIGITS low-order digits are kept. An item
// without is_last passes through wait, multiply and add. A closing item
// then runs the conversion: the restoring divider shifts out one quotient
// bit per cycle, so each digit costs a full pass over all VALUE_BITS bits,
// and each digit is read from the digit store, waits for a free output slot
// and is moved into the output register. The output register holds the
// final digit while the next number is accepted.
// Configuration writes are taken at any time but belong in idle periods.
// ----------------------------------------------------------------------------
`include "radix_conversion_top_defines.svh"

module radix_conversion_top
  import rc_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BASE_W-1:0]    cfg_data_i,
  // input digits
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  // output digits
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o
);

  status_t status;
  op_e     op;
  logic    in_accept;

  // registers are plain flops, always writable
  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && in_ready_o;

  // microprogram: sequencing and branch decisions
  rc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .op_o       (op)
  );

  // datapath driven by the current control word
  rc_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_accept_i (in_accept),
    .in_data_i   (in_data_i),
    .op_i        (op),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // a digit is loaded only when the output slot is empty or being taken
  `RC_ASSERT_SAME(a_push_slot_free, op == OP_PUSH, !status.out_full, "push into full output slot")

  // one input transaction at a time
  `RC_ASSERT_NEXT(a_one_in_flight, in_accept, !in_ready_o, "input taken twice in a row")

  // emitted characters stay within 0-9 and A-Z
  `RC_ASSERT_SAME(a_digit_legal, out_valid_o, (out_data_o.digit_out >= 7'd48 && out_data_o.digit_out <= 7'd57) || (out_data_o.digit_out >= 7'd65 && out_data_o.digit_out <= 7'd90), "illegal output digit")

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Radix conversion testbench
// Feeds digit strings through radix_conversion_top under several radix
// settings and checks every emitted digit against a cycle-free model of
// the accumulate-and-convert behavior.
// ----------------------------------------------------------------------------
module tb_top;
  import rc_pkg::*;

  localparam int VALUE_BITS = 32;
  localparam int MAX_DIGITS = 32;
  // watchdog bound: room for the worst number plus its output stalls,
  // taken about three times over for every item sent
  localparam int LIMIT      = 2_000_000;
  // settle time after the last digit, covers a plain digit in flight
  localparam int IDLE_GAP   = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 40;
  localparam int PHASE_ITEMS = 30;

  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_NINE   = 8'd57;
  localparam logic [7:0] CH_LETTER = 8'd55;

  // --------------------------------------------------------------------------
  // clock, reset and DUT hookup
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BASE_W-1:0]    cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_data   = '0;
  logic                 out_valid_o;
  logic                 out_ready = 1'b0;
  out_item_t            out_data_o;

  radix_conversion_top #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  // --------------------------------------------------------------------------
  // shared state
  // --------------------------------------------------------------------------
  in_item_t  char_queue[$];      // characters waiting to be offered
  out_item_t digits_due[$];      // digits the block still owes us
  int        errors     = 0;
  int        n_accepted = 0;     // input transactions taken so far
  int        cycle_cnt  = 0;
  int        send_gap   = 0;
  int        stall_left = 0;
  int        hold_left  = 0;
  bit        hold_used  = 1'b0;
  bit        calm       = 1'b0;  // no idling on either side when set

  // model copy of the block's registers and accumulator
  logic [BASE_W-1:0]     in_base_q  = IN_BASE_RST;
  logic [BASE_W-1:0]     out_base_q = OUT_BASE_RST;
  logic [VALUE_BITS-1:0] acc_value  = '0;

  // --------------------------------------------------------------------------
  // model
  // --------------------------------------------------------------------------
  function automatic logic [7:0] to_ascii(int d);
    return (d >= 10) ? 8'(d) + CH_LETTER : 8'(d) + CH_ZERO;
  endfunction

  // fold one character into the accumulator; a closing character queues the
  // converted digits, most significant first
  function automatic void convert_char(in_item_t it);
    logic [VALUE_BITS-1:0] cval;
    logic [VALUE_BITS-1:0] v;
    int                    b;
    int                    n;
    int                    rem[MAX_DIGITS];
    out_item_t             d;
    if (it.char_in >= CH_ZERO && it.char_in <= CH_NINE) begin
      cval = VALUE_BITS'(it.char_in - CH_ZERO);
    end else begin
      // non-digits below '7' wrap around modulo 2^VALUE_BITS
      cval = VALUE_BITS'(it.char_in) - VALUE_BITS'(CH_LETTER);
    end
    acc_value = VALUE_BITS'(acc_value * VALUE_BITS'(in_base_q) + cval);
    if (!it.is_last) return;
    b = int'(out_base_q);
    if (b < 2) b = 2;
    if (b > 36) b = 36;
    v = acc_value;
    n = 0;
    do begin
      rem[n] = int'(v % VALUE_BITS'(b));
      n++;
      v = v / VALUE_BITS'(b);
    end while (v != 0 && n < MAX_DIGITS);
    for (int k = n - 1; k >= 0; k--) begin
      d.digit_out  = DIGIT_W'(to_ascii(rem[k]));
      d.last_digit = (k == 0);
      digits_due.push_back(d);
    end
    acc_value = '0;
  endfunction

  // --------------------------------------------------------------------------
  // input driver: offers queued characters, idles in random bursts
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : driver
    in_item_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready_o) begin
        convert_char(in_data);
        n_accepted++;
      end
      if (in_valid && !in_ready_o) begin
        // transaction still pending: hold valid and payload
      end else if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (char_queue.size() != 0) begin
        nxt = char_queue.pop_front();
        in_valid <= 1'b1;
        in_data  <= nxt;
        if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // long receiver hold-off: once enough input has gone in, block the output
  // for a long stretch so the block backs up and stalls its input
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : holdoff
    if (!rst_ni) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (!hold_used && n_accepted >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // output monitor: checks each digit transaction against the oldest
  // expectation, stalls in random bursts
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_item_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (digits_due.size() == 0) begin
          $display("%0t: unexpected digit, expected none, actual %h", $time, out_data_o);
          errors++;
        end else begin
          want = digits_due.pop_front();
          if (out_data_o.digit_out !== want.digit_out) begin
            $display("%0t: digit_out expected %h actual %h",
                     $time, want.digit_out, out_data_o.digit_out);
            errors++;
          end
          if (out_data_o.last_digit !== want.last_digit) begin
            $display("%0t: last_digit expected %b actual %b",
                     $time, want.last_digit, out_data_o.last_digit);
            errors++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      out_ready <= (stall_left == 0) && (hold_left == 0);
    end
  end

  // --------------------------------------------------------------------------
  // watchdog
  // --------------------------------------------------------------------------
  initial begin : watchdog
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(reg_idx_e idx, logic [BASE_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == REG_IN_BASE) in_base_q = val;
    else out_base_q = val;
  endtask

  task automatic send_char(logic [7:0] c, logic last);
    in_item_t it;
    it.char_in = c;
    it.is_last = last;
    char_queue.push_back(it);
  endtask

  // sender stops until every digit is back, then lets any plain digit settle
  task automatic wait_idle();
    do @(posedge clk_i);
    while (char_queue.size() != 0 || in_valid || digits_due.size() != 0);
    repeat (IDLE_GAP) @(posedge clk_i);
  endtask

  // mostly well-formed numbers in the current in_base, plus raw noise
  task automatic fill_random(int count);
    int added;
    int len;
    int top;
    added = 0;
    top = (in_base_q >= 2 && in_base_q <= 36) ? int'(in_base_q) - 1 : 35;
    while (added < count) begin
      if ($urandom_range(0, 4) == 0) begin
        send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        added++;
      end else begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          send_char(to_ascii($urandom_range(0, top)), i == len - 1);
        end
        added += len;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin : sequencer
    int in_tbl[8];
    int out_tbl[8];
    in_tbl  = '{2, 36, 10, 16, 36, 1, 63, 0};
    out_tbl = '{2, 36, 16, 10, 2, 37, 0, 63};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset radices 10 -> 16
    send_char("0", 1'b1);             // zero value gives a lone "0"
    send_char("1", 1'b0);
    send_char("2", 1'b0);
    send_char("3", 1'b1);             // 123 -> 7B
    send_char(8'h00, 1'b1);           // non-digit below '7' wraps
    send_char(8'hFF, 1'b1);           // top character code
    send_char("Z", 1'b1);             // digit not below in_base
    wait_idle();

    // all ones in base 2: the longest digit string
    write_reg(REG_IN_BASE, 6'd16);
    write_reg(REG_OUT_BASE, 6'd2);
    for (int i = 0; i < 8; i++) send_char("F", i == 7);
    wait_idle();

    write_reg(REG_IN_BASE, 6'd36);
    write_reg(REG_OUT_BASE, 6'd36);
    send_char("Z", 1'b0);
    send_char("Z", 1'b1);
    wait_idle();

    // in_base 0 keeps only the last digit, out_base 0 acts as 2
    write_reg(REG_IN_BASE, 6'd0);
    write_reg(REG_OUT_BASE, 6'd0);
    send_char("7", 1'b0);
    send_char("5", 1'b1);
    wait_idle();

    // both registers at their top code, out_base acts as 36
    write_reg(REG_IN_BASE, 6'd63);
    write_reg(REG_OUT_BASE, 6'd63);
    send_char("1", 1'b0);
    send_char("1", 1'b1);
    wait_idle();

    // random phases over a spread of radix pairs; the final one runs
    // without idling
    for (int p = 0; p < 10; p++) begin
      if (p < 8) begin
        write_reg(REG_IN_BASE, BASE_W'(in_tbl[p]));
        write_reg(REG_OUT_BASE, BASE_W'(out_tbl[p]));
      end else begin
        write_reg(REG_IN_BASE, BASE_W'($urandom_range(0, 63)));
        write_reg(REG_OUT_BASE, BASE_W'($urandom_range(0, 63)));
      end
      calm = (p == 9);
      fill_random(PHASE_ITEMS);
      wait_idle();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
